// ===== hdl/htsd_pkg.sv =====
// ----------------------------------------------------------------------------
// htsd_pkg
// shared types and constants of the huffman tree stream decoder
// ----------------------------------------------------------------------------
package htsd_pkg;

  localparam int MaxNodes = 1024;
  localparam int MaxDepth = 64;
  localparam int NodeAw   = $clog2(MaxNodes);
  localparam int NodeCw   = NodeAw + 1;
  localparam int StackAw  = $clog2(MaxDepth);
  localparam int DepthW   = StackAw + 1;

  localparam logic KindByte   = 1'b0;
  localparam logic KindStatus = 1'b1;

  typedef struct packed {
    logic [NodeAw-1:0] left;
    logic [NodeAw-1:0] right;
    logic              leaf;
    logic              endm;
    logic [7:0]        value;
  } node_t;

  localparam int NodeW = $bits(node_t);

  localparam node_t MaskFull  = '1;
  localparam node_t MaskLeft  = '{left: '1, right: '0, leaf: 1'b0, endm: 1'b0, value: '0};
  localparam node_t MaskRight = '{left: '0, right: '1, leaf: 1'b0, endm: 1'b0, value: '0};

  typedef struct packed {
    logic              fill;
    logic [NodeAw-1:0] idx;
  } stk_t;

  localparam int StkW = $bits(stk_t);

  typedef struct packed {
    logic       kind;
    logic [7:0] dbyte;
    logic       last;
    logic       endm;
    logic       ok;
    logic       err;
  } out_item_t;

endpackage

// ===== hdl/htsd_ram.sv =====
// ----------------------------------------------------------------------------
// htsd_ram
// single port write, single port read ram with bit write mask, registered read
// ----------------------------------------------------------------------------
module htsd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [Width-1:0]         wmask_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      for (int b = 0; b < Width; b++) begin
        if (wmask_i[b]) begin
          mem[waddr_i][b] <= wdata_i[b];
        end
      end
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/htsd_out.sv =====
// ----------------------------------------------------------------------------
// htsd_out
// output register holding one result item
// ----------------------------------------------------------------------------
module htsd_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  htsd_pkg::out_item_t item_i,
  output logic                push_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output htsd_pkg::out_item_t item_o
);

  logic                valid_q, valid_d;
  htsd_pkg::out_item_t item_q;

  assign push_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (push_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      item_q <= item_i;
    end
  end

  assign out_valid_o = valid_q;
  assign item_o      = item_q;

endmodule

// ===== hdl/htsd_ctrl.sv =====
// ----------------------------------------------------------------------------
// htsd_ctrl
// bit sequencer: tree header parse into node table, code walk, status items
// ----------------------------------------------------------------------------
module htsd_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          new_stream_i,
  input  logic [7:0]                    data_byte_i,
  output logic                          node_we_o,
  output htsd_pkg::node_t               node_wmask_o,
  output logic [htsd_pkg::NodeAw-1:0]   node_waddr_o,
  output htsd_pkg::node_t               node_wdata_o,
  output logic                          node_re_o,
  output logic [htsd_pkg::NodeAw-1:0]   node_raddr_o,
  input  htsd_pkg::node_t               node_rdata_i,
  output logic                          stk_we_o,
  output logic [htsd_pkg::StackAw-1:0]  stk_waddr_o,
  output htsd_pkg::stk_t                stk_wdata_o,
  output logic                          stk_re_o,
  output logic [htsd_pkg::StackAw-1:0]  stk_raddr_o,
  input  htsd_pkg::stk_t                stk_rdata_i,
  output logic                          push_o,
  output htsd_pkg::out_item_t           item_o,
  input  logic                          push_ready_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_BIT, S_DEV, S_ATT, S_ATT_LD, S_STAT
  } state_e;

  typedef enum logic [2:0] {
    P_NODE, P_KIND, P_VALUE, P_CHECK, P_DATA
  } phase_e;

  state_e                       state_q, state_d;
  phase_e                       phase_q, phase_d;
  logic [7:0]                   byte_q, byte_d;
  logic [2:0]                   pos_q, pos_d;
  logic [htsd_pkg::NodeCw-1:0]  cnt_q, cnt_d;
  logic [htsd_pkg::DepthW-1:0]  depth_q, depth_d;
  logic [htsd_pkg::NodeAw-1:0]  top_q, top_d;
  logic                         fill_q, fill_d;
  logic [7:0]                   val_q, val_d;
  logic [2:0]                   vcnt_q, vcnt_d;
  logic [htsd_pkg::NodeAw-1:0]  child_q, child_d;
  logic [htsd_pkg::NodeAw-1:0]  cur_l_q, cur_l_d, cur_r_q, cur_r_d;
  logic [htsd_pkg::NodeAw-1:0]  root_l_q, root_l_d, root_r_q, root_r_d;
  logic [7:0]                   exp_q, exp_d, run_q, run_d;
  logic                         final_q, final_d;
  logic                         err_q, err_d;

  logic                         bit_v;
  logic [htsd_pkg::NodeAw-1:0]  n_new, n_last;
  logic [7:0]                   val_nx;

  assign bit_v  = byte_q[pos_q];
  assign n_new  = cnt_q[htsd_pkg::NodeAw-1:0];
  assign n_last = htsd_pkg::NodeAw'(cnt_q - htsd_pkg::NodeCw'(1));
  assign val_nx = val_q | (8'(bit_v) << vcnt_q);
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    byte_d   = byte_q;
    pos_d    = pos_q;
    cnt_d    = cnt_q;
    depth_d  = depth_q;
    top_d    = top_q;
    fill_d   = fill_q;
    val_d    = val_q;
    vcnt_d   = vcnt_q;
    child_d  = child_q;
    cur_l_d  = cur_l_q;
    cur_r_d  = cur_r_q;
    root_l_d = root_l_q;
    root_r_d = root_r_q;
    exp_d    = exp_q;
    run_d    = run_q;
    final_d  = final_q;
    err_d    = err_q;

    node_we_o    = 1'b0;
    node_wmask_o = htsd_pkg::MaskFull;
    node_waddr_o = n_new;
    node_wdata_o = '0;
    node_re_o    = 1'b0;
    node_raddr_o = bit_v ? cur_r_q : cur_l_q;
    stk_we_o     = 1'b0;
    stk_waddr_o  = htsd_pkg::StackAw'(depth_q - htsd_pkg::DepthW'(1));
    stk_wdata_o  = '{fill: fill_q, idx: top_q};
    stk_re_o     = 1'b0;
    stk_raddr_o  = htsd_pkg::StackAw'(depth_q - htsd_pkg::DepthW'(2));
    push_o       = 1'b0;
    item_o       = '{kind: htsd_pkg::KindStatus, dbyte: 8'd0, last: 1'b1, endm: final_q,
                     ok: final_q && (exp_q == run_q) && !err_q, err: err_q};

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          byte_d = data_byte_i;
          pos_d  = 3'd7;
          if (new_stream_i) begin
            phase_d  = P_NODE;
            cnt_d    = '0;
            depth_d  = '0;
            val_d    = '0;
            vcnt_d   = '0;
            cur_l_d  = '0;
            cur_r_d  = '0;
            root_l_d = '0;
            root_r_d = '0;
            exp_d    = '0;
            run_d    = '0;
            final_d  = 1'b0;
            err_d    = 1'b0;
            state_d  = S_BIT;
          end else if (err_q) begin
            state_d = S_STAT;
          end else if (phase_q == P_CHECK) begin
            exp_d   = data_byte_i;
            phase_d = P_DATA;
            cur_l_d = root_l_q;
            cur_r_d = root_r_q;
            state_d = S_STAT;
          end else begin
            state_d = S_BIT;
          end
        end
      end
      S_BIT: begin
        state_d = (pos_q == 3'd0) ? S_STAT : S_BIT;
        pos_d   = pos_q - 3'd1;
        unique case (phase_q)
          P_NODE: begin
            if (cnt_q >= htsd_pkg::NodeCw'(htsd_pkg::MaxNodes)) begin
              err_d   = 1'b1;
              state_d = S_STAT;
            end else begin
              node_we_o = 1'b1;
              cnt_d     = cnt_q + htsd_pkg::NodeCw'(1);
              if (!bit_v) begin
                if (depth_q >= htsd_pkg::DepthW'(htsd_pkg::MaxDepth)) begin
                  err_d   = 1'b1;
                  state_d = S_STAT;
                end else begin
                  stk_we_o = (depth_q != '0);
                  top_d    = n_new;
                  fill_d   = 1'b0;
                  depth_d  = depth_q + htsd_pkg::DepthW'(1);
                end
              end else if (n_new == '0) begin
                err_d   = 1'b1;
                state_d = S_STAT;
              end else begin
                phase_d = P_KIND;
              end
            end
          end
          P_KIND: begin
            node_we_o    = 1'b1;
            node_waddr_o = n_last;
            node_wdata_o = '{left: '0, right: '0, leaf: 1'b1, endm: bit_v, value: 8'd0};
            if (bit_v) begin
              child_d = n_last;
              state_d = S_ATT;
              pos_d   = pos_q;
            end else begin
              phase_d = P_VALUE;
              val_d   = '0;
              vcnt_d  = '0;
            end
          end
          P_VALUE: begin
            if (vcnt_q == 3'd7) begin
              node_we_o    = 1'b1;
              node_waddr_o = n_last;
              node_wdata_o = '{left: '0, right: '0, leaf: 1'b1, endm: 1'b0, value: val_nx};
              child_d      = n_last;
              val_d        = '0;
              vcnt_d       = '0;
              state_d      = S_ATT;
              pos_d        = pos_q;
            end else begin
              val_d  = val_nx;
              vcnt_d = vcnt_q + 3'd1;
            end
          end
          P_DATA: begin
            node_re_o = 1'b1;
            state_d   = S_DEV;
            pos_d     = pos_q;
          end
          default: begin
            state_d = S_STAT;
            pos_d   = pos_q;
          end
        endcase
      end
      S_DEV: begin
        final_d = 1'b0;
        if (node_rdata_i.leaf) begin
          if (node_rdata_i.endm) begin
            final_d = 1'b1;
            cur_l_d = root_l_q;
            cur_r_d = root_r_q;
            state_d = S_STAT;
          end else if (push_ready_i) begin
            push_o  = 1'b1;
            item_o  = '{kind: htsd_pkg::KindByte, dbyte: node_rdata_i.value, last: 1'b0,
                        endm: 1'b0, ok: 1'b0, err: err_q};
            run_d   = run_q ^ node_rdata_i.value;
            cur_l_d = root_l_q;
            cur_r_d = root_r_q;
            state_d = (pos_q == 3'd0) ? S_STAT : S_BIT;
            pos_d   = pos_q - 3'd1;
          end
        end else begin
          cur_l_d = node_rdata_i.left;
          cur_r_d = node_rdata_i.right;
          state_d = (pos_q == 3'd0) ? S_STAT : S_BIT;
          pos_d   = pos_q - 3'd1;
        end
      end
      S_ATT: begin
        node_waddr_o = top_q;
        node_wdata_o = '{left: child_q, right: child_q, leaf: 1'b0, endm: 1'b0, value: 8'd0};
        if (depth_q == '0) begin
          phase_d = P_CHECK;
          state_d = S_STAT;
        end else if (!fill_q) begin
          node_we_o    = 1'b1;
          node_wmask_o = htsd_pkg::MaskLeft;
          if (top_q == '0) begin
            root_l_d = child_q;
          end
          fill_d  = 1'b1;
          phase_d = P_NODE;
          state_d = (pos_q == 3'd0) ? S_STAT : S_BIT;
          pos_d   = pos_q - 3'd1;
        end else begin
          node_we_o    = 1'b1;
          node_wmask_o = htsd_pkg::MaskRight;
          if (top_q == '0) begin
            root_r_d = child_q;
          end
          depth_d = depth_q - htsd_pkg::DepthW'(1);
          child_d = top_q;
          if (depth_q == htsd_pkg::DepthW'(1)) begin
            phase_d = P_CHECK;
            state_d = S_STAT;
          end else begin
            stk_re_o = 1'b1;
            state_d  = S_ATT_LD;
          end
        end
      end
      S_ATT_LD: begin
        top_d   = stk_rdata_i.idx;
        fill_d  = stk_rdata_i.fill;
        state_d = S_ATT;
      end
      S_STAT: begin
        if (push_ready_i) begin
          push_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= P_NODE;
      byte_q   <= '0;
      pos_q    <= '0;
      cnt_q    <= '0;
      depth_q  <= '0;
      top_q    <= '0;
      fill_q   <= 1'b0;
      val_q    <= '0;
      vcnt_q   <= '0;
      child_q  <= '0;
      cur_l_q  <= '0;
      cur_r_q  <= '0;
      root_l_q <= '0;
      root_r_q <= '0;
      exp_q    <= '0;
      run_q    <= '0;
      final_q  <= 1'b0;
      err_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      byte_q   <= byte_d;
      pos_q    <= pos_d;
      cnt_q    <= cnt_d;
      depth_q  <= depth_d;
      top_q    <= top_d;
      fill_q   <= fill_d;
      val_q    <= val_d;
      vcnt_q   <= vcnt_d;
      child_q  <= child_d;
      cur_l_q  <= cur_l_d;
      cur_r_q  <= cur_r_d;
      root_l_q <= root_l_d;
      root_r_q <= root_r_d;
      exp_q    <= exp_d;
      run_q    <= run_d;
      final_q  <= final_d;
      err_q    <= err_d;
    end
  end

endmodule

// ===== hdl/huffman_tree_stream_decoder_unit.sv =====
// a header bit is parsed in the bit state; after the last bit of a leaf the attach state hangs
// the leaf on its parent, plus a node write, then a parse stack read, per non-root parent
// it completes; a code bit takes a node table read, then an evaluation of the node read
// a checksum byte or a byte after an error goes from accept straight to the status item
// one byte is worked on at a time and ends with a status item; output stalls hold the sequencer
// reset clears control state; node table and parse stack contents are undefined until written
// ----------------------------------------------------------------------------
// huffman_tree_stream_decoder_unit
// huffman decoder whose code tree is carried in the stream header
// ----------------------------------------------------------------------------
module huffman_tree_stream_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       new_stream_i,
  input  logic [7:0] data_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       item_kind_o,
  output logic [7:0] decoded_byte_o,
  output logic       last_of_run_o,
  output logic       end_marker_seen_o,
  output logic       stream_ok_o,
  output logic       error_flag_o
);

  logic                          node_we, node_re;
  htsd_pkg::node_t               node_wmask, node_wdata, node_rdata;
  logic [htsd_pkg::NodeAw-1:0]   node_waddr, node_raddr;
  logic                          stk_we, stk_re;
  logic [htsd_pkg::StackAw-1:0]  stk_waddr, stk_raddr;
  htsd_pkg::stk_t                stk_wdata, stk_rdata;
  logic                          push, push_ready;
  htsd_pkg::out_item_t           item, out_item;

  htsd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .new_stream_i (new_stream_i),
    .data_byte_i  (data_byte_i),
    .node_we_o    (node_we),
    .node_wmask_o (node_wmask),
    .node_waddr_o (node_waddr),
    .node_wdata_o (node_wdata),
    .node_re_o    (node_re),
    .node_raddr_o (node_raddr),
    .node_rdata_i (node_rdata),
    .stk_we_o     (stk_we),
    .stk_waddr_o  (stk_waddr),
    .stk_wdata_o  (stk_wdata),
    .stk_re_o     (stk_re),
    .stk_raddr_o  (stk_raddr),
    .stk_rdata_i  (stk_rdata),
    .push_o       (push),
    .item_o       (item),
    .push_ready_i (push_ready)
  );

  htsd_ram #(
    .Width (htsd_pkg::NodeW),
    .Depth (htsd_pkg::MaxNodes)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (node_we),
    .wmask_i (node_wmask),
    .waddr_i (node_waddr),
    .wdata_i (node_wdata),
    .re_i    (node_re),
    .raddr_i (node_raddr),
    .rdata_o (node_rdata)
  );

  htsd_ram #(
    .Width (htsd_pkg::StkW),
    .Depth (htsd_pkg::MaxDepth)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .wmask_i ({htsd_pkg::StkW{1'b1}}),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  htsd_out u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .item_i       (item),
    .push_ready_o (push_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .item_o       (out_item)
  );

  assign item_kind_o       = out_item.kind;
  assign decoded_byte_o    = out_item.dbyte;
  assign last_of_run_o     = out_item.last;
  assign end_marker_seen_o = out_item.endm;
  assign stream_ok_o       = out_item.ok;
  assign error_flag_o      = out_item.err;

endmodule
